// File: rtl/periodic_timer_slot_bank_top_macros.svh
// assertion macros shared by the periodic timer slot bank rtl
// expects clk and rst in scope at the point of use
`ifndef PERIODIC_TIMER_SLOT_BANK_TOP_MACROS_SVH
`define PERIODIC_TIMER_SLOT_BANK_TOP_MACROS_SVH

// property that must hold in the same cycle
`define PTSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a property in the next
`define PTSB_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: rtl/ptsb_pkg.sv
// types and constants for the periodic timer slot bank
// used by the front, command queue, slot engine and top level
`timescale 1ns / 1ps

package ptsb_pkg;

  localparam int HID_W      = 16;
  localparam int PER_W      = 17;
  localparam int TIME_W     = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int S_DATA_W   = 72;
  localparam int M_DATA_W   = 24;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = 2;
  localparam int CQ_CNT_W = 3;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD_ACK    = 2'd0;
  localparam logic [1:0] KIND_REMOVE_ACK = 2'd1;
  localparam logic [1:0] KIND_FIRE       = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // countdown value that means the slot never fires
  localparam logic [PER_W-1:0] NEVER = {PER_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_REMOVE,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [HID_W-1:0]   hid;
    logic               hid_zero;
    logic [PER_W-1:0]   period;
    logic [PER_W-1:0]   init_cd;
    logic [TIME_W-1:0]  time_now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [HID_W-1:0]      handler;
    logic                  last;
  } res_t;

endpackage

// File: rtl/ptsb_front.sv
// input side of the timer slot bank: takes stream words, decodes the opcode
// and hands classified commands to the command queue; uses ptsb_pkg
`timescale 1ns / 1ps

module ptsb_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ptsb_pkg::S_DATA_W-1:0]    s_tdata,   // handler_id, period, time_now, pad
  input  logic [1:0]                       s_tuser,   // opcode
  output logic                             cmd_valid,
  input  logic                             cmd_ready,
  output ptsb_pkg::cmd_t                   cmd
);
  import ptsb_pkg::*;

  logic             f_vld;
  cmd_t             f_cmd;
  cmd_t             dec_cmd;
  logic             dec_ok;
  logic             take;
  logic [HID_W-1:0] in_hid;
  logic [PER_W-1:0] in_per;

  assign in_hid = s_tdata[HID_W-1:0];
  assign in_per = s_tdata[HID_W+PER_W-1:HID_W];

  always_comb begin
    dec_ok           = 1'b1;
    dec_cmd.kind     = CMD_ADD;
    dec_cmd.hid      = in_hid;
    dec_cmd.hid_zero = (in_hid == '0);
    dec_cmd.period   = in_per;
    dec_cmd.init_cd  = (in_per == NEVER) ? NEVER : PER_W'(1);
    dec_cmd.time_now = s_tdata[HID_W+PER_W+TIME_W-1:HID_W+PER_W];
    case (s_tuser)
      OP_ADD:    dec_cmd.kind = CMD_ADD;
      OP_REMOVE: dec_cmd.kind = CMD_REMOVE;
      OP_TICK:   dec_cmd.kind = CMD_TICK;
      default:   dec_ok = 1'b0;   // reserved opcode is dropped
    endcase
  end

  assign s_tready  = !f_vld || cmd_ready;
  assign take      = s_tvalid && s_tready;
  assign cmd_valid = f_vld;
  assign cmd       = f_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      if (take && dec_ok) begin
        f_vld <= 1'b1;
        f_cmd <= dec_cmd;
      end else if (cmd_ready) begin
        f_vld <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ptsb_cmd_queue.sv
// short command queue between the decode front and the slot engine
// depth and types from ptsb_pkg
`timescale 1ns / 1ps

module ptsb_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ptsb_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output ptsb_pkg::cmd_t out_cmd
);
  import ptsb_pkg::*;

  cmd_t                q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != CQ_CNT_W'(CQ_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CQ_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CQ_CNT_W'(1);
        2'b01:   count <= count - CQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/ptsb_slot_engine.sv
// slot engine: slot table memory, active bits, slot walker and result register
// takes commands from the queue; types from ptsb_pkg, assertions from the macro header
`timescale 1ns / 1ps
`include "periodic_timer_slot_bank_top_macros.svh"

module ptsb_slot_engine #(
  parameter int SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  ptsb_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output ptsb_pkg::res_t res
);
  import ptsb_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_RM,
    ST_TICK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [HID_W-1:0] handler;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] countdown;
  } entry_t;

  state_t              state;
  logic [SLOT_W-1:0]   idx;
  logic [SLOTS-1:0]    active;
  logic [TIME_W-1:0]   prev_time;
  cmd_t                cur;
  res_t                hold;
  logic                hold_vld;
  logic                out_vld;
  res_t                out_res;

  entry_t              mem [SLOTS];
  entry_t              rdata;
  logic [SLOT_W-1:0]   raddr;
  logic                we;
  entry_t              wdata;

  logic                out_free;
  logic                out_load;
  logic                last_idx;
  logic                hit;
  logic                live;
  logic [PER_W-1:0]    dec;
  logic                fire;
  logic                step;
  logic                scan;

  assign out_free  = !out_vld || res_ready;
  assign last_idx  = (idx == SLOT_W'(SLOTS - 1));
  assign hit       = !active[idx];
  assign live      = active[idx] && (rdata.countdown != NEVER);
  assign dec       = rdata.countdown - PER_W'(1);
  assign fire      = live && (dec == '0);
  assign scan      = (state == ST_RM) || (state == ST_TICK);
  assign cmd_ready = (state == ST_IDLE);
  assign res_valid = out_vld;
  assign res       = out_res;

  always_comb begin
    case (state)
      ST_ADD:  step = (hit || last_idx) ? out_free : 1'b1;
      ST_RM:   step = last_idx ? out_free : 1'b1;
      ST_TICK: step = !(fire && hold_vld && !out_free);
      default: step = 1'b0;
    endcase
  end

  // a new word goes to the output register this cycle
  assign out_load = ((state == ST_ADD) && step && (hit || last_idx)) ||
                    ((state == ST_RM) && step && last_idx) ||
                    ((state == ST_TICK) && step && fire && hold_vld) ||
                    ((state == ST_FLUSH) && out_free);

  // read one slot ahead so the registered data lines up with idx
  always_comb begin
    if (scan && !(step && last_idx)) begin
      raddr = step ? idx + SLOT_W'(1) : idx;
    end else begin
      raddr = '0;
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    if (state == ST_ADD && step && hit) begin
      we              = 1'b1;
      wdata.handler   = cur.hid;
      wdata.period    = cur.period;
      wdata.countdown = cur.init_cd;
    end else if (state == ST_TICK && step && live) begin
      we              = 1'b1;
      wdata.countdown = fire ? rdata.period : dec;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      active    <= '0;
      prev_time <= '0;
      hold_vld  <= 1'b0;
      out_vld   <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (res_ready) begin
        out_vld <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            case (cmd.kind)
              CMD_ADD:    state <= ST_ADD;
              CMD_REMOVE: state <= ST_RM;
              CMD_TICK: begin
                // same time as before: nothing to do
                if (cmd.time_now != prev_time) begin
                  prev_time <= cmd.time_now;
                  state     <= ST_TICK;
                end
              end
              default:    state <= ST_IDLE;
            endcase
          end
        end
        ST_ADD: begin
          if (step) begin
            if (hit) begin
              active[idx] <= 1'b1;
              out_res     <= '{KIND_ADD_ACK, STATUS_OK, SLOT_OUT_W'(idx), '0, 1'b1};
              state       <= ST_IDLE;
              idx         <= '0;
            end else if (last_idx) begin
              out_res <= '{KIND_ADD_ACK, STATUS_FULL, '0, '0, 1'b1};
              state   <= ST_IDLE;
              idx     <= '0;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end
        ST_RM: begin
          if (step) begin
            if (active[idx] && !cur.hid_zero && rdata.handler == cur.hid) begin
              active[idx] <= 1'b0;
            end
            if (last_idx) begin
              out_res <= '{KIND_REMOVE_ACK, STATUS_OK, '0, '0, 1'b1};
              state   <= ST_IDLE;
              idx     <= '0;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end
        ST_TICK: begin
          if (step) begin
            // a fire is held back until the next one shows whether it is the last
            if (fire) begin
              if (hold_vld) begin
                out_res <= hold;
              end
              hold     <= '{KIND_FIRE, STATUS_OK, SLOT_OUT_W'(idx), rdata.handler, 1'b0};
              hold_vld <= 1'b1;
            end
            if (last_idx) begin
              state <= (hold_vld || fire) ? ST_FLUSH : ST_IDLE;
              idx   <= '0;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_res  <= '{hold.kind, hold.status, hold.slot, hold.handler, 1'b1};
            hold_vld <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
          idx   <= '0;
        end
      endcase
    end
  end

  `PTSB_ASSERT(a_idle_idx_zero, (state != ST_IDLE) || (idx == '0), "walker index not parked in idle")
  `PTSB_ASSERT(a_hold_in_tick, !hold_vld || state == ST_TICK || state == ST_FLUSH, "pending fire outside tick")
  `PTSB_ASSERT(a_ack_is_last, !out_vld || out_res.kind == KIND_FIRE || out_res.last, "acknowledge without last")
  `PTSB_ASSERT_NEXT(a_add_sets_active, state == ST_ADD && step && hit, active[$past(idx)], "add did not claim slot")

endmodule

// File: rtl/periodic_timer_slot_bank_top.sv
// periodic timer slot bank: a bank of SLOTS timer slots driven by add, remove
// and tick commands; a decode front and a queue feed a slot engine that walks the
// slots one per cycle through its table memory, stalling for a full output
// register. An add walks up to the first free slot (all slots if none is free);
// a remove or a tick with a new time walks every slot, plus a flush step when any
// timer fires, and each fire result past the first waits for the previous one to
// be taken. A repeated tick time walks no slot, and the unused opcode is dropped
// by the front. Up to four commands wait in the queue while the engine is busy.
// depends on ptsb_pkg, ptsb_front, ptsb_cmd_queue, ptsb_slot_engine
`timescale 1ns / 1ps

module periodic_timer_slot_bank_top #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ptsb_pkg::S_DATA_W-1:0] s_tdata,   // handler_id[15:0], period[32:16], time_now[64:33], zero pad
  input  logic [1:0]                    s_tuser,   // opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ptsb_pkg::M_DATA_W-1:0] m_tdata,   // status[0], slot[4:1], fired_handler[20:5], zero pad
  output logic [1:0]                    m_tuser,   // kind
  output logic                          m_tlast
);
  import ptsb_pkg::*;

  logic fc_valid;
  logic fc_ready;
  cmd_t fc_cmd;
  logic qe_valid;
  logic qe_ready;
  cmd_t qe_cmd;
  res_t res;

  ptsb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (fc_valid),
    .cmd_ready (fc_ready),
    .cmd       (fc_cmd)
  );

  ptsb_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fc_valid),
    .in_ready  (fc_ready),
    .in_cmd    (fc_cmd),
    .out_valid (qe_valid),
    .out_ready (qe_ready),
    .out_cmd   (qe_cmd)
  );

  ptsb_slot_engine #(
    .SLOTS (SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qe_valid),
    .cmd_ready (qe_ready),
    .cmd       (qe_cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {3'b000, res.handler, res.slot, res.status};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule
